[rtl/enir_pkg.sv]
package enir_pkg;

    // Nominal NEC timings in microseconds.
    localparam logic [13:0] HDR_MARK_US   = 14'd9000;
    localparam logic [13:0] HDR_SPACE_US  = 14'd4500;
    localparam logic [13:0] BIT_MARK_US   = 14'd560;
    localparam logic [13:0] ONE_SPACE_US  = 14'd1690;
    localparam logic [13:0] ZERO_SPACE_US = 14'd560;

    localparam int          PCT_SCALE     = 100;
    localparam logic [6:0]  TOL_RESET     = 7'd25;

    typedef struct packed {
        logic hdr_ok;
        logic bit_ok;
        logic bit_one;
    } pulse_class_t;

    typedef struct packed {
        logic        status;
        logic [15:0] address;
        logic [15:0] command;
        logic [15:0] command_two;
        logic [15:0] repeat_count;
    } result_t;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    // True when d lies within floor(n*(100-tol)/100) .. floor(n*(100+tol)/100).
    // Both bounds are tested by cross-multiplying, so no divider is needed:
    // d >= floor(x/100) holds exactly when 100*(d+1) > x, and
    // d <= floor(x/100) holds exactly when 100*d <= x.
    function automatic logic near_nominal(input logic [15:0] d,
                                          input logic [6:0]  tol,
                                          input logic [13:0] n);
        logic [23:0] d_scaled;
        logic [23:0] d_next_scaled;
        logic [7:0]  lo_pct;
        logic [7:0]  hi_pct;
        logic [23:0] lo_prod;
        logic [23:0] hi_prod;
        logic        lo_ok;
        logic        hi_ok;
        d_scaled      = 24'(d) * 24'(PCT_SCALE);
        d_next_scaled = d_scaled + 24'(PCT_SCALE);
        lo_pct        = 8'(PCT_SCALE) - 8'(tol);
        hi_pct        = 8'(PCT_SCALE) + 8'(tol);
        lo_prod       = 24'(lo_pct) * 24'(n);
        hi_prod       = 24'(hi_pct) * 24'(n);
        lo_ok         = (tol >= 7'(PCT_SCALE)) || (d_next_scaled > lo_prod);
        hi_ok         = (d_scaled <= hi_prod);
        return lo_ok && hi_ok;
    endfunction

endpackage

[rtl/enir_classify.sv]
module enir_classify (
    input  logic [15:0]            mark_us,
    input  logic [15:0]            space_us,
    input  logic [6:0]             tolerance_pct,
    output enir_pkg::pulse_class_t cls
);
    import enir_pkg::*;

    logic mark_ok;
    logic one_ok;
    logic zero_ok;

    assign mark_ok = near_nominal(mark_us, tolerance_pct, BIT_MARK_US);
    assign one_ok  = near_nominal(space_us, tolerance_pct, ONE_SPACE_US);
    assign zero_ok = near_nominal(space_us, tolerance_pct, ZERO_SPACE_US);

    always_comb begin
        cls.hdr_ok  = near_nominal(mark_us, tolerance_pct, HDR_MARK_US)
                   && near_nominal(space_us, tolerance_pct, HDR_SPACE_US);
        cls.bit_ok  = mark_ok && (one_ok || zero_ok);
        // The one pattern wins when both space windows overlap.
        cls.bit_one = one_ok;
    end

endmodule

[rtl/enir_frame.sv]
module enir_frame (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  enir_pkg::pulse_class_t cls,
    output logic                   emit,
    output enir_pkg::result_t      result
);
    import enir_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ADDR = 4'b0010,
        PH_CMD  = 4'b0100,
        PH_REP  = 4'b1000
    } phase_t;

    localparam logic [4:0]  LAST_HALF_BIT = 5'd15;
    localparam logic [4:0]  LAST_BIT      = 5'd31;
    localparam logic [15:0] REPEAT_MAX    = 16'hFFFF;

    phase_t      phase_reg, phase_next;
    logic [4:0]  bit_index_reg, bit_index_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [15:0] cmd_two_reg, cmd_two_next;
    logic [15:0] rep_cmd_reg, rep_cmd_next;
    logic [15:0] rep_cmd_two_reg, rep_cmd_two_next;
    logic [15:0] repeat_reg, repeat_next;
    logic        good;

    always_comb begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        addr_next        = addr_reg;
        cmd_next         = cmd_reg;
        cmd_two_next     = cmd_two_reg;
        rep_cmd_next     = rep_cmd_reg;
        rep_cmd_two_next = rep_cmd_two_reg;
        repeat_next      = repeat_reg;
        emit             = 1'b0;
        good             = 1'b0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (cls.hdr_ok) begin
                    phase_next       = PH_ADDR;
                    bit_index_next   = '0;
                    addr_next        = '0;
                    cmd_next         = '0;
                    cmd_two_next     = '0;
                    rep_cmd_next     = '0;
                    rep_cmd_two_next = '0;
                    repeat_next      = 16'd1;
                end
            end
            PH_ADDR: begin
                if (!cls.bit_ok) begin
                    emit = 1'b1;
                end else begin
                    addr_next[bit_index_reg[3:0]] = cls.bit_one;
                    if (bit_index_reg >= LAST_HALF_BIT) begin
                        phase_next     = PH_CMD;
                        bit_index_next = '0;
                    end else begin
                        bit_index_next = bit_index_reg + 5'd1;
                    end
                end
            end
            PH_CMD: begin
                if (!cls.bit_ok) begin
                    emit = 1'b1;
                end else begin
                    if (bit_index_reg[4]) begin
                        cmd_two_next[bit_index_reg[3:0]] = cls.bit_one;
                    end else begin
                        cmd_next[bit_index_reg[3:0]] = cls.bit_one;
                    end
                    if (bit_index_reg == LAST_BIT) begin
                        phase_next     = PH_REP;
                        bit_index_next = '0;
                    end else begin
                        bit_index_next = bit_index_reg + 5'd1;
                    end
                end
            end
            PH_REP: begin
                if (!cls.bit_ok) begin
                    // Only a clean end at a group boundary is a good frame.
                    emit = 1'b1;
                    good = (bit_index_reg == '0);
                end else begin
                    if (bit_index_reg[4]) begin
                        rep_cmd_two_next[bit_index_reg[3:0]] = cls.bit_one;
                    end else begin
                        rep_cmd_next[bit_index_reg[3:0]] = cls.bit_one;
                    end
                    if (bit_index_reg == LAST_BIT) begin
                        // Compare with the group just completed, last bit included.
                        if (rep_cmd_next != cmd_reg || rep_cmd_two_next != cmd_two_reg) begin
                            emit = 1'b1;
                        end else if (repeat_reg != REPEAT_MAX) begin
                            repeat_next = repeat_reg + 16'd1;
                        end
                        bit_index_next = '0;
                    end else begin
                        bit_index_next = bit_index_reg + 5'd1;
                    end
                end
            end
            default: begin
                phase_next     = PH_IDLE;
                bit_index_next = '0;
            end
        endcase

        if (emit) begin
            phase_next     = PH_IDLE;
            bit_index_next = '0;
        end

        result.status       = good ? STATUS_GOOD : STATUS_BAD;
        result.address      = good ? addr_reg    : '0;
        result.command      = good ? cmd_reg     : '0;
        result.command_two  = good ? cmd_two_reg : '0;
        result.repeat_count = good ? repeat_reg  : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_index_reg <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            addr_reg        <= addr_next;
            cmd_reg         <= cmd_next;
            cmd_two_reg     <= cmd_two_next;
            rep_cmd_reg     <= rep_cmd_next;
            rep_cmd_two_reg <= rep_cmd_two_next;
            repeat_reg      <= repeat_next;
        end
    end

endmodule

[rtl/ext_nec_ir_decoder.sv]
// Extended NEC infrared frame decoder.
//
// The slave channel carries one request per measured mark/space pair; the
// master channel returns one request per finished frame, either a good frame
// with its address, both command words and the repeat count, or a bad-frame
// flag with an all-zero payload. Pairs that do not end a frame give nothing.
//
// Each accepted pair sits in an input register until the output register
// can take a result; it is then classified against the nominal timings and
// updates the frame state, and any result lands in the output register,
// from which it is valid on the master side. A new pair can be accepted on
// every cycle while the master side keeps up.
//
// Write the tolerance register via cfg_we/cfg_wdata only while the block is idle,
// not checked by the block. Reset sets it to 25 percent. A synchronous low on
// aresetn returns the decoder to waiting for a header and empties both registers.
//
// When the master side stalls, a waiting result is held; the input register
// can still take one further pair, after which s_tready falls until the
// result has been taken.
module ext_nec_ir_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,      // tolerance_pct

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // [15:0] mark_us, [31:16] space_us

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,        // [15:0] address, [31:16] command,
                                        // [47:32] command_two, [63:48] repeat_count
    output logic [0:0]  m_tuser         // [0] frame_status
);
    import enir_pkg::*;

    logic [6:0]   tol_reg;
    logic         in_valid_reg;
    logic [15:0]  in_mark_reg;
    logic [15:0]  in_space_reg;
    logic         out_valid_reg;
    result_t      out_res_reg;

    logic         out_free;
    logic         advance;
    logic         emit;
    pulse_class_t cls;
    result_t      result;

    // The stored pair is processed whenever the output register can take a
    // possible result in the same edge.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mark_reg  <= s_tdata[15:0];
            in_space_reg <= s_tdata[31:16];
        end
    end

    enir_classify u_classify (
        .mark_us       (in_mark_reg),
        .space_us      (in_space_reg),
        .tolerance_pct (tol_reg),
        .cls           (cls)
    );

    enir_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cls     (cls),
        .emit    (emit),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_res_reg.repeat_count, out_res_reg.command_two,
                         out_res_reg.command, out_res_reg.address};
    assign m_tuser[0] = out_res_reg.status;

    // A bad frame never carries decoded words.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == STATUS_BAD) |-> (m_tdata == '0))
        else $error("bad-frame result with non-zero payload");

    // A good frame always counts at least one command group.
    a_good_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == STATUS_GOOD) |-> (m_tdata[63:48] != '0))
        else $error("good frame with zero repeat count");

    // An empty input register never holds off the sender.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");

    // A result produced by the frame logic is presented on the next cycle.
    a_emit_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> m_tvalid)
        else $error("frame result lost");

endmodule
